// ----- hw/rtl/fragment_reassembler_defines.svh -----
// assertion macros for the fragment reassembler
// used by fragment_reassembler.sv, expects i_clk and i_rst_n in scope
`ifndef FRAGMENT_REASSEMBLER_DEFINES_SVH
`define FRAGMENT_REASSEMBLER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define FR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define FR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/fr_pkg.sv -----
// shared types, codes and the crc byte step for the fragment reassembler
// no dependencies
`default_nettype none
package fr_pkg;

    localparam int HEADER_BYTES = 9;

    localparam logic [1:0] CMD_FRAME = 2'd0;
    localparam logic [1:0] CMD_TAKE  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FRAG_ERR  = 2'd1;
    localparam logic [1:0] ST_CRC_ERR   = 2'd2;

    localparam logic [1:0] CFG_PROTOCOL = 2'd0;
    localparam logic [1:0] CFG_LEGACY   = 2'd1;
    localparam logic [1:0] CFG_LEG_EN   = 2'd2;
    localparam logic [1:0] CFG_CAPACITY = 2'd3;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  status;
        logic        message_ready;
        logic        took;
        logic [7:0]  message_kind;
        logic [15:0] sequence_res;
        logic [9:0]  message_bytes;
        logic [7:0]  read_byte;
    } t_result;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/fr_ifs.sv -----
// valid/ready channel interfaces for the fragment reassembler
// no dependencies
`default_nettype none
interface fr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] data_byte;
    logic       frame_last;
    logic [9:0] read_index;
    modport source (output valid, cmd, data_byte, frame_last, read_index, input ready);
    modport sink   (input valid, cmd, data_byte, frame_last, read_index, output ready);
endinterface

interface fr_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        message_ready;
    logic        took;
    logic [7:0]  message_kind;
    logic [15:0] sequence_res;
    logic [9:0]  message_bytes;
    logic [7:0]  read_byte;
    modport source (output valid, status, message_ready, took, message_kind, sequence_res,
                    message_bytes, read_byte, input ready);
    modport sink   (input valid, status, message_ready, took, message_kind, sequence_res,
                    message_bytes, read_byte, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/fr_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none
module fr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- hw/rtl/fragment_reassembler.sv -----
// Fragment reassembler. A frame byte without the last mark is taken in the idle state. On the
// last byte the header is checked in S_CHECK; if it passes, the payload is copied from the
// frame memory into the message memory at one byte a cycle, and on the final fragment the
// CRC-16/CCITT walks the message memory one byte a cycle. Take goes through S_RESP, read
// through S_RDW (message memory read port) and then S_RESP.
// The result waits in an output register; the input is held off while an item is worked.
// Depends on fr_pkg, fr_ifs, fr_ram and fragment_reassembler_defines.svh.
`default_nettype none
`include "fragment_reassembler_defines.svh"
module fragment_reassembler #(
    parameter int MAX_FRAME_BYTES = 32,
    parameter int MESSAGE_DEPTH   = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    fr_in_if.sink            i_in,
    fr_out_if.source         o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [10:0] i_cfg_data
);
    localparam int FW  = $clog2(MAX_FRAME_BYTES + 1);
    localparam int FAW = $clog2(MAX_FRAME_BYTES);
    localparam int AW  = $clog2(MESSAGE_DEPTH);
    localparam int LW  = 11;

    typedef enum logic [2:0] {S_IDLE, S_CHECK, S_COPY, S_CRC, S_RDW, S_RESP} t_state;

    t_state          r_state;
    logic [7:0]      r_pver, r_lver;
    logic            r_len_en;
    logic [10:0]     r_cap;
    logic [FW-1:0]   r_fill;
    logic            r_too_long;
    logic [7:0]      r_hdr [fr_pkg::HEADER_BYTES];
    logic [7:0]      r_kind, r_ni, r_ec;
    logic [15:0]     r_seq, r_ecrc, r_crc;
    logic [LW-1:0]   r_held, r_j;
    logic            r_ready;
    logic [7:0]      r_i;
    logic            r_wv, r_cv, r_rd_ok;
    logic [AW-1:0]   r_wa;
    fr_pkg::t_result r_res, r_out;
    logic            r_out_valid;

    // frame memory
    logic            f_we;
    logic [7:0]      f_rdata;
    logic [8:0]      f_raddr9;
    assign f_we     = (r_state == S_IDLE) && i_in.valid && (i_in.cmd == fr_pkg::CMD_FRAME)
                      && (r_fill < FW'(MAX_FRAME_BYTES));
    assign f_raddr9 = 9'(fr_pkg::HEADER_BYTES) + 9'(r_i);

    fr_ram #(.WIDTH(8), .DEPTH(MAX_FRAME_BYTES)) u_frame_ram (
        .i_clk(i_clk), .i_we(f_we), .i_waddr(r_fill[FAW-1:0]), .i_wdata(i_in.data_byte),
        .i_raddr(f_raddr9[FAW-1:0]), .o_rdata(f_rdata)
    );

    // message memory
    logic [7:0]  m_rdata;
    logic [AW-1:0] m_raddr;
    logic [16:0] rd_ix17, crc_ix17, wa17;
    assign rd_ix17  = 17'(i_in.read_index);
    assign crc_ix17 = 17'(r_j);
    assign wa17     = 17'(r_held) + 17'(r_i);
    assign m_raddr  = (r_state == S_CRC) ? crc_ix17[AW-1:0] : rd_ix17[AW-1:0];

    fr_ram #(.WIDTH(8), .DEPTH(MESSAGE_DEPTH)) u_msg_ram (
        .i_clk(i_clk), .i_we(r_wv && (r_state == S_COPY)), .i_waddr(r_wa), .i_wdata(f_rdata),
        .i_raddr(m_raddr), .o_rdata(m_rdata)
    );

    // header checks
    logic [16:0] cap_eff;
    logic [7:0]  pay, idx, cnt;
    logic        ver_ok, bad_frame, restart, seq_bad;
    logic [7:0]  ni_eff, ec_eff;
    logic [LW-1:0] held_eff;
    logic [FW-1:0] fill_inc;
    assign cap_eff  = (17'(r_cap) > 17'(MESSAGE_DEPTH)) ? 17'(MESSAGE_DEPTH) : 17'(r_cap);
    assign idx      = r_hdr[4];
    assign cnt      = r_hdr[5];
    assign pay      = r_hdr[6];
    assign ver_ok   = (r_hdr[0] == r_pver) || (r_len_en && (r_hdr[0] == r_lver));
    assign bad_frame = r_too_long || (cap_eff == 17'd0) || (r_fill < FW'(fr_pkg::HEADER_BYTES))
                      || !ver_ok || (cnt == 8'd0) || (pay == 8'd0)
                      || (9'(r_fill) != 9'(fr_pkg::HEADER_BYTES) + 9'(pay));
    assign restart  = (idx == 8'd0);
    assign ni_eff   = restart ? 8'd0 : r_ni;
    assign ec_eff   = restart ? cnt : r_ec;
    assign held_eff = restart ? '0 : r_held;
    assign seq_bad  = (idx != ni_eff) || (cnt != ec_eff)
                      || ((17'(held_eff) + 17'(pay)) >= cap_eff);
    assign fill_inc = r_fill + FW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pver      <= 8'd1;
            r_lver      <= 8'd0;
            r_len_en    <= 1'b0;
            r_cap       <= 11'd1024;
            r_fill      <= '0;
            r_too_long  <= 1'b0;
            r_kind      <= '0;
            r_seq       <= '0;
            r_ecrc      <= '0;
            r_ec        <= '0;
            r_ni        <= '0;
            r_held      <= '0;
            r_ready     <= 1'b0;
            r_wv        <= 1'b0;
            r_cv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    fr_pkg::CFG_PROTOCOL: r_pver   <= i_cfg_data[7:0];
                    fr_pkg::CFG_LEGACY:   r_lver   <= i_cfg_data[7:0];
                    fr_pkg::CFG_LEG_EN:   r_len_en <= i_cfg_data[0];
                    fr_pkg::CFG_CAPACITY: r_cap    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_res <= '0;
                        r_res.message_ready <= r_ready;
                        unique case (i_in.cmd)
                            fr_pkg::CMD_FRAME: begin
                                if (f_we) begin
                                    r_fill <= fill_inc;
                                    for (int k = 0; k < fr_pkg::HEADER_BYTES; k++) begin
                                        if (r_fill == FW'(k)) begin
                                            r_hdr[k] <= i_in.data_byte;
                                        end
                                    end
                                end else begin
                                    r_too_long <= 1'b1;
                                end
                                if (i_in.frame_last) begin
                                    r_state <= S_CHECK;
                                end
                            end
                            fr_pkg::CMD_TAKE: begin
                                if (r_ready) begin
                                    r_res.took          <= 1'b1;
                                    r_res.message_kind  <= r_kind;
                                    r_res.sequence_res  <= r_seq;
                                    r_res.message_bytes <= r_held[9:0];
                                    r_res.message_ready <= 1'b0;
                                    r_kind <= '0; r_seq <= '0; r_ecrc <= '0; r_ec <= '0;
                                    r_ni <= '0; r_held <= '0; r_ready <= 1'b0;
                                end
                                r_state <= S_RESP;
                            end
                            fr_pkg::CMD_READ: begin
                                r_rd_ok <= rd_ix17 < 17'(MESSAGE_DEPTH);
                                r_state <= S_RDW;
                            end
                            default: ;
                        endcase
                    end
                end
                S_CHECK: begin
                    // frame fill is cleared here, the header stays in r_hdr
                    r_fill     <= '0;
                    r_too_long <= 1'b0;
                    r_res.status <= fr_pkg::ST_FRAG_ERR;
                    if (bad_frame) begin
                        r_res.message_ready <= r_ready;
                        r_state <= S_RESP;
                    end else begin
                        if (restart) begin
                            r_kind <= r_hdr[1];
                            r_seq  <= {r_hdr[2], r_hdr[3]};
                            r_ecrc <= {r_hdr[7], r_hdr[8]};
                            r_ec   <= cnt;
                            r_ni   <= '0;
                            r_held <= '0;
                            r_ready <= 1'b0;
                        end
                        r_res.message_ready <= restart ? 1'b0 : r_ready;
                        r_i <= '0;
                        r_state <= seq_bad ? S_RESP : S_COPY;
                    end
                end
                S_COPY: begin
                    r_wv <= 1'b0;
                    if (r_i < pay) begin
                        r_wv <= 1'b1;
                        r_wa <= wa17[AW-1:0];
                        r_i  <= r_i + 8'd1;
                    end else if (!r_wv) begin
                        r_held <= r_held + LW'(pay);
                        r_ni   <= r_ni + 8'd1;
                        r_res.status <= fr_pkg::ST_OK;
                        if (8'(r_ni + 8'd1) == r_ec) begin
                            r_crc <= fr_pkg::CRC_INIT;
                            r_j   <= '0;
                            r_cv  <= 1'b0;
                            r_state <= S_CRC;
                        end else begin
                            r_state <= S_RESP;
                        end
                    end
                end
                S_CRC: begin
                    r_cv <= 1'b0;
                    if (r_cv) begin
                        r_crc <= fr_pkg::crc_byte(r_crc, m_rdata);
                    end
                    if (r_j < r_held) begin
                        r_cv <= 1'b1;
                        r_j  <= r_j + LW'(1);
                    end else if (!r_cv) begin
                        if (r_crc != r_ecrc) begin
                            r_kind <= '0; r_seq <= '0; r_ecrc <= '0; r_ec <= '0;
                            r_ni <= '0; r_held <= '0; r_ready <= 1'b0;
                            r_res.status <= fr_pkg::ST_CRC_ERR;
                            r_res.message_ready <= 1'b0;
                        end else begin
                            r_ready <= 1'b1;
                            r_res.message_ready <= 1'b1;
                        end
                        r_state <= S_RESP;
                    end
                end
                S_RDW: begin
                    r_res.read_byte <= r_rd_ok ? m_rdata : 8'd0;
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_out.status;
    assign o_out.message_ready = r_out.message_ready;
    assign o_out.took          = r_out.took;
    assign o_out.message_kind  = r_out.message_kind;
    assign o_out.sequence_res  = r_out.sequence_res;
    assign o_out.message_bytes = r_out.message_bytes;
    assign o_out.read_byte     = r_out.read_byte;

    `FR_ASSERT_NOW(a_copy_in_cap, r_wv && (r_state == S_COPY), 17'(r_wa) < cap_eff, "copy beyond capacity")
    `FR_ASSERT_NOW(a_took_clears, o_out.valid && o_out.took, !o_out.message_ready, "take left message ready")
    `FR_ASSERT_NOW(a_crc_err_clear, o_out.valid && (o_out.status == fr_pkg::ST_CRC_ERR), !o_out.message_ready, "crc error with message ready")
    `FR_ASSERT_NEXT(a_ready_from_crc, !r_ready && (r_state != S_CRC), !r_ready, "ready set outside crc check")

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
// self-checking testbench for fragment_reassembler: frame, take and read beats in, results out
// uses fr_pkg and the fr_in_if / fr_out_if channels from the rtl; a scoreboard class predicts
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int         FRAME_MAX  = 32;
    localparam int         STORE_SIZE = 1024;

    class reassembly_scoreboard;
        logic [7:0]  proto_ver;
        logic [7:0]  legacy_ver;
        logic        legacy_en;
        logic [10:0] capacity;
        logic [7:0]  frame_buf [FRAME_MAX];
        int unsigned frame_fill;
        bit          frame_overrun;
        logic [7:0]  kind_q;
        logic [15:0] seq_q;
        logic [15:0] crc_q;
        logic [7:0]  count_q;
        logic [7:0]  next_idx;
        int unsigned held_len;
        bit          msg_ready;
        logic [7:0]  msg_mem [STORE_SIZE];
        int unsigned written_top;
        fr_pkg::t_result expected_results[$];
        int unsigned errors;

        function new();
            proto_ver = 8'd1;
            legacy_ver = 8'd0;
            legacy_en = 1'b0;
            capacity = 11'd1024;
            frame_fill = 0;
            frame_overrun = 0;
            written_top = 0;
            errors = 0;
            clear_message();
        endfunction

        static function logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
            logic [15:0] c;
            c = crc ^ {b, 8'h00};
            for (int k = 0; k < 8; k++)
                c = c[15] ? ({c[14:0], 1'b0} ^ fr_pkg::CRC_POLY) : {c[14:0], 1'b0};
            return c;
        endfunction

        function void clear_message();
            kind_q = 0;
            seq_q = 0;
            crc_q = 0;
            count_q = 0;
            next_idx = 0;
            held_len = 0;
            msg_ready = 0;
        endfunction

        function void configure(logic [1:0] idx, logic [10:0] v);
            case (idx)
                fr_pkg::CFG_PROTOCOL: proto_ver = v[7:0];
                fr_pkg::CFG_LEGACY:   legacy_ver = v[7:0];
                fr_pkg::CFG_LEG_EN:   legacy_en = v[0];
                fr_pkg::CFG_CAPACITY: capacity = v;
                default: ;
            endcase
        endfunction

        function logic [1:0] close_frame();
            int unsigned cap;
            int unsigned pay;
            logic [7:0]  idx;
            logic [7:0]  cnt;
            logic [15:0] c;
            cap = (capacity > STORE_SIZE) ? STORE_SIZE : 32'(capacity);
            if (frame_overrun || cap == 0 || frame_fill < fr_pkg::HEADER_BYTES)
                return fr_pkg::ST_FRAG_ERR;
            if (!(frame_buf[0] == proto_ver || (legacy_en && frame_buf[0] == legacy_ver)))
                return fr_pkg::ST_FRAG_ERR;
            idx = frame_buf[4];
            cnt = frame_buf[5];
            pay = 32'(frame_buf[6]);
            if (cnt == 0 || pay == 0 || frame_fill != fr_pkg::HEADER_BYTES + pay)
                return fr_pkg::ST_FRAG_ERR;
            // index zero starts a new message
            if (idx == 0) begin
                kind_q = frame_buf[1];
                seq_q = {frame_buf[2], frame_buf[3]};
                crc_q = {frame_buf[7], frame_buf[8]};
                count_q = cnt;
                next_idx = 0;
                held_len = 0;
                msg_ready = 0;
            end
            if (idx != next_idx || cnt != count_q) return fr_pkg::ST_FRAG_ERR;
            if (held_len + pay >= cap) return fr_pkg::ST_FRAG_ERR;
            for (int i = 0; i < pay; i++)
                msg_mem[held_len + i] = frame_buf[fr_pkg::HEADER_BYTES + i];
            held_len += pay;
            if (held_len > written_top) written_top = held_len;
            next_idx = next_idx + 8'd1;
            if (next_idx == count_q) begin
                c = fr_pkg::CRC_INIT;
                for (int i = 0; i < held_len; i++) c = crc_step(c, msg_mem[i]);
                if (c != crc_q) begin
                    clear_message();
                    return fr_pkg::ST_CRC_ERR;
                end
                msg_ready = 1;
            end
            return fr_pkg::ST_OK;
        endfunction

        function void predict_beat(logic [1:0] cmd, logic [7:0] data, logic last,
                                   logic [9:0] ridx);
            fr_pkg::t_result r;
            r = '0;
            case (cmd)
                fr_pkg::CMD_FRAME: begin
                    if (frame_fill < FRAME_MAX) begin
                        frame_buf[frame_fill] = data;
                        frame_fill++;
                    end else begin
                        frame_overrun = 1;
                    end
                    if (!last) return;
                    r.status = close_frame();
                    r.message_ready = msg_ready;
                    frame_fill = 0;
                    frame_overrun = 0;
                end
                fr_pkg::CMD_TAKE: begin
                    if (msg_ready) begin
                        r.took = 1;
                        r.message_kind = kind_q;
                        r.sequence_res = seq_q;
                        r.message_bytes = held_len[9:0];
                        clear_message();
                    end
                    r.message_ready = msg_ready;
                end
                fr_pkg::CMD_READ: begin
                    r.read_byte = msg_mem[ridx];
                    r.message_ready = msg_ready;
                end
                default: return;
            endcase
            expected_results.push_back(r);
        endfunction

        function void check_result(fr_pkg::t_result got);
            fr_pkg::t_result e;
            if (expected_results.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
                return;
            end
            e = expected_results.pop_front();
            if (got.status !== e.status) begin
                $error("status expected %0d got %0d", e.status, got.status); errors++;
            end
            if (got.message_ready !== e.message_ready) begin
                $error("message_ready expected %0d got %0d", e.message_ready,
                       got.message_ready); errors++;
            end
            if (got.took !== e.took) begin
                $error("took expected %0d got %0d", e.took, got.took); errors++;
            end
            if (got.message_kind !== e.message_kind) begin
                $error("message_kind expected %0h got %0h", e.message_kind,
                       got.message_kind); errors++;
            end
            if (got.sequence_res !== e.sequence_res) begin
                $error("sequence_res expected %0h got %0h", e.sequence_res,
                       got.sequence_res); errors++;
            end
            if (got.message_bytes !== e.message_bytes) begin
                $error("message_bytes expected %0d got %0d", e.message_bytes,
                       got.message_bytes); errors++;
            end
            if (got.read_byte !== e.read_byte) begin
                $error("read_byte expected %0h got %0h", e.read_byte, got.read_byte); errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [10:0] cfg_data;

    fr_in_if  in_ch();
    fr_out_if out_ch();

    fragment_reassembler u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    reassembly_scoreboard sb = new();
    int burst_left = 0;
    int hold_cycles = 0;
    int beats_sent = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // result side: check accepted beats, stall on a pattern of its own
    initial begin
        int pat_cnt;
        int mode;
        fr_pkg::t_result r;
        pat_cnt = 0;
        mode = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) begin
                r.status = out_ch.status;
                r.message_ready = out_ch.message_ready;
                r.took = out_ch.took;
                r.message_kind = out_ch.message_kind;
                r.sequence_res = out_ch.sequence_res;
                r.message_bytes = out_ch.message_bytes;
                r.read_byte = out_ch.read_byte;
                sb.check_result(r);
            end
            if (++pat_cnt == 48) begin
                pat_cnt = 0;
                mode = int'($urandom_range(0, 2));
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                out_ch.ready <= 1'b0;
            end else begin
                case (mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= 1'($urandom_range(0, 1));
                    default: out_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic send_beat(logic [1:0] cmd, logic [7:0] data, logic last, logic [9:0] ridx);
        if (burst_left <= 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : int'($urandom_range(1, 12));
        end
        in_ch.valid <= 1'b1;
        in_ch.cmd <= cmd;
        in_ch.data_byte <= data;
        in_ch.frame_last <= last;
        in_ch.read_index <= ridx;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.predict_beat(cmd, data, last, ridx);
        burst_left--;
        if (cmd != CMD_UNUSED) beats_sent++;
    endtask

    task automatic send_frame(logic [7:0] bytes[$]);
        for (int i = 0; i < bytes.size(); i++)
            send_beat(fr_pkg::CMD_FRAME, bytes[i], i == bytes.size() - 1, 10'($urandom));
    endtask

    task automatic take_msg();
        send_beat(fr_pkg::CMD_TAKE, 8'($urandom), 1'($urandom), 10'($urandom));
    endtask

    task automatic read_msg();
        if (sb.written_top > 0)
            send_beat(fr_pkg::CMD_READ, 8'($urandom), 1'($urandom),
                      10'($urandom_range(0, sb.written_top - 1)));
    endtask

    // builds a message of nfrag fragments; corrupt_pct spoils single frames
    task automatic send_message(int nfrag, int minpay, int maxpay, bit bad_crc,
                                int corrupt_pct);
        int          plen[];
        logic [7:0]  body[$];
        logic [7:0]  fr[$];
        logic [15:0] crc;
        logic [7:0]  kind;
        logic [15:0] seqn;
        int          pos;
        plen = new[nfrag];
        crc = fr_pkg::CRC_INIT;
        kind = 8'($urandom);
        seqn = 16'($urandom);
        for (int f = 0; f < nfrag; f++) begin
            plen[f] = int'($urandom_range(minpay, maxpay));
            for (int i = 0; i < plen[f]; i++) begin
                body.push_back(8'($urandom));
                crc = reassembly_scoreboard::crc_step(crc, body[$]);
            end
        end
        if (bad_crc) crc ^= 16'($urandom_range(1, 16'hFFFF));
        pos = 0;
        for (int f = 0; f < nfrag; f++) begin
            fr = {};
            fr.push_back((sb.legacy_en && $urandom_range(0, 1)) ? sb.legacy_ver : sb.proto_ver);
            fr.push_back(kind);
            fr.push_back(seqn[15:8]);
            fr.push_back(seqn[7:0]);
            fr.push_back(f[7:0]);
            fr.push_back(nfrag[7:0]);
            fr.push_back(plen[f][7:0]);
            fr.push_back(crc[15:8]);
            fr.push_back(crc[7:0]);
            for (int i = 0; i < plen[f]; i++) fr.push_back(body[pos + i]);
            pos += plen[f];
            if ($urandom_range(0, 99) < corrupt_pct) begin
                case ($urandom_range(0, 5))
                    0: fr[0] = fr[0] ^ (8'd1 << $urandom_range(0, 7));
                    1: fr[5] = 8'd0;
                    2: void'(fr.pop_back());
                    3: while (fr.size() < 36) fr.push_back(8'($urandom));
                    4: fr[4] = fr[4] + 8'($urandom_range(1, 3));
                    default: while (fr.size() > 4) void'(fr.pop_back());
                endcase
            end
            send_frame(fr);
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_regs(logic [7:0] pv, logic [7:0] lv, logic en, logic [10:0] cap);
        logic [10:0] vals[4];
        vals[fr_pkg::CFG_PROTOCOL] = {3'd0, pv};
        vals[fr_pkg::CFG_LEGACY] = {3'd0, lv};
        vals[fr_pkg::CFG_LEG_EN] = {10'd0, en};
        vals[fr_pkg::CFG_CAPACITY] = cap;
        for (int i = 0; i < 4; i++) begin
            cfg_we <= 1'b1;
            cfg_index <= i[1:0];
            cfg_data <= vals[i];
            @(posedge i_clk);
            sb.configure(i[1:0], vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    initial begin
        logic [7:0] fr[$];
        i_rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        in_ch.valid <= 1'b0;
        in_ch.cmd <= fr_pkg::CMD_FRAME;
        in_ch.data_byte <= '0;
        in_ch.frame_last <= 1'b0;
        in_ch.read_index <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset settings
        take_msg();
        send_message(1, 1, 23, 0, 0);
        read_msg();
        take_msg();
        take_msg();
        send_message(2, 23, 23, 1, 0);
        send_message(1, 5, 5, 0, 100);
        send_message(3, 1, 8, 0, 100);
        fr = {8'h01, 8'h00, 8'h00};
        send_frame(fr);
        fr = {8'h01, 8'h10, 8'h20, 8'h30, 8'h00, 8'h01, 8'h00, 8'hFF, 8'hFF};
        send_frame(fr);
        fr = {8'hFF};
        send_frame(fr);
        send_beat(CMD_UNUSED, 8'hFF, 1'b1, 10'h3FF);
        send_beat(fr_pkg::CMD_FRAME, 8'h01, 1'b0, 10'h000);
        send_beat(fr_pkg::CMD_FRAME, 8'h00, 1'b1, 10'h000);
        drain();

        // small store: fill it, then overflow it
        write_regs(8'h01, 8'h00, 1'b0, 11'd60);
        send_message(2, 23, 23, 0, 0);
        read_msg();
        take_msg();
        send_message(3, 23, 23, 0, 0);
        repeat (4) read_msg();
        drain();

        write_regs(8'h00, 8'hFF, 1'b1, 11'd2047);
        send_message(2, 1, 23, 0, 0);
        take_msg();
        drain();
        write_regs(8'hFF, 8'h00, 1'b1, 11'd0);
        send_message(1, 1, 10, 0, 0);
        take_msg();
        drain();
        write_regs(8'hA5, 8'h5A, 1'b1, 11'd1);
        send_message(1, 1, 4, 0, 0);
        drain();
        write_regs(8'h07, 8'h03, 1'b0, 11'd30);
        send_message(2, 10, 20, 0, 0);
        take_msg();
        drain();

        // random part, opened by a long receiver stall
        hold_cycles = 400;
        while (beats_sent < 900) begin
            if ($urandom_range(0, 19) == 0 && hold_cycles == 0)
                hold_cycles = 400;
            case ($urandom_range(0, 9))
                0: begin
                    fr = {};
                    repeat ($urandom_range(1, 40)) fr.push_back(8'($urandom));
                    send_frame(fr);
                end
                1: send_beat(CMD_UNUSED, 8'($urandom), 1'($urandom), 10'($urandom));
                default: send_message(($urandom_range(0, 7) == 0)
                                      ? int'($urandom_range(5, 12))
                                      : int'($urandom_range(1, 3)), 1,
                                      ($urandom_range(0, 1) ? 23 : 6),
                                      $urandom_range(0, 6) == 0, 12);
            endcase
            if ($urandom_range(0, 1)) take_msg();
            repeat ($urandom_range(0, 2)) read_msg();
            if ($urandom_range(0, 59) == 0) begin
                drain();
                write_regs(8'($urandom), 8'($urandom), 1'($urandom),
                           ($urandom_range(0, 3) == 0) ? 11'($urandom_range(0, 2047))
                           : 11'($urandom_range(200, 1024)));
            end
        end

        drain();
        repeat (1200) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire
